>>> hw/rtl/stle_pkg.sv
// ----------------------------------------------------------------------------
// stle_pkg
// Shared types and constants for the string table line extractor.
// ----------------------------------------------------------------------------
package stle_pkg;

    typedef enum logic [1:0] {
        MODE_SEEK_ID = 2'd0,
        MODE_SKIP    = 2'd1,
        MODE_STREAM  = 2'd2,
        MODE_DONE    = 2'd3
    } scan_mode_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    localparam logic [15:0] SAT_16  = 16'hFFFF;

    localparam int unsigned ADDR_W  = 3;
    localparam logic        REG_TARGET_ID   = 1'b0;
    localparam logic        REG_PIECE_INDEX = 1'b1;

endpackage

>>> hw/rtl/string_table_line_extractor_core.sv
// ----------------------------------------------------------------------------
// string_table_line_extractor_core
// Scans a text block byte by byte and streams the text of one keyed line.
// ----------------------------------------------------------------------------
// Input stream (s_*): one text byte per word in s_tdata[7:0]; a zero byte
// ends the block. Lines are "<decimal id><tab><text>" ended by CR or LF.
// Output stream (m_*): bytes of the text of the first line whose id equals
// target_id, or only the bar-separated piece selected by piece_index when it
// is not negative. The zero byte yields one closing word with m_tlast high,
// m_tdata zero and m_tuser[0] set if a matching line was seen; the scan state
// then clears.
// Timing: a byte is decoded in the cycle it is accepted and its result sits
// in the output register on the next cycle. One word is taken per cycle
// unless the output stalls. The output register is the only stage, so
// s_tready follows m_tready while a result is pending.
// Reset: aresetn (synchronous, active low) clears the scan state and the output
// valid flag, and sets target_id to 0 and piece_index to -1.
// Configuration over APB: target_id at 0x0, piece_index at 0x4; write only
// while the stream is idle.
// ----------------------------------------------------------------------------
module string_table_line_extractor_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata: [7:0] data_byte
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    // m_tdata: [7:0] out_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast,
    // m_tuser: [0] matched
    output logic [0:0]                  m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stle_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [14:0]          target_id_reg;
    logic signed [15:0]   piece_index_reg;

    stle_pkg::scan_mode_t mode_reg, mode_next;
    logic [15:0]          id_accum_reg, id_accum_next;
    logic [15:0]          bar_count_reg, bar_count_next;
    logic                 seen_match_reg, seen_match_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_matched_reg, out_matched_next;

    logic                 in_accept;
    logic                 emit;
    logic [7:0]           c;
    logic                 is_digit, is_eol, is_nul, is_bar, id_hit, piece_hit;
    logic [19:0]          id_mul;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_id_reg   <= 15'd0;
            piece_index_reg <= -16'sd1;
        end else if (cfg_write) begin
            case (paddr[2])
                stle_pkg::REG_TARGET_ID:   target_id_reg   <= pwdata[14:0];
                stle_pkg::REG_PIECE_INDEX: piece_index_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            stle_pkg::REG_TARGET_ID:   prdata = {17'd0, target_id_reg};
            stle_pkg::REG_PIECE_INDEX: prdata = {{16{piece_index_reg[15]}}, piece_index_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign c         = s_tdata;
    assign is_nul    = (c == stle_pkg::CH_NUL);
    assign is_digit  = (c >= stle_pkg::CH_ZERO) && (c <= stle_pkg::CH_NINE);
    assign is_eol    = (c == stle_pkg::CH_CR) || (c == stle_pkg::CH_LF);
    assign is_bar    = (c == stle_pkg::CH_BAR);
    assign id_hit    = (id_accum_reg == {1'b0, target_id_reg});
    assign piece_hit = (bar_count_reg == piece_index_reg[15:0]);
    assign id_mul    = ({4'd0, id_accum_reg} * 20'd10) + {16'd0, c[3:0]};

    // next state
    always_comb begin
        mode_next       = mode_reg;
        id_accum_next   = id_accum_reg;
        bar_count_next  = bar_count_reg;
        seen_match_next = seen_match_reg;
        if (in_accept) begin
            if (is_nul) begin
                mode_next       = stle_pkg::MODE_SEEK_ID;
                id_accum_next   = 16'd0;
                bar_count_next  = 16'd0;
                seen_match_next = 1'b0;
            end else begin
                case (mode_reg)
                    stle_pkg::MODE_SEEK_ID: begin
                        if (is_digit) begin
                            id_accum_next = (id_mul > {4'd0, stle_pkg::SAT_16}) ?
                                            stle_pkg::SAT_16 : id_mul[15:0];
                        end else if (c == stle_pkg::CH_TAB) begin
                            if (id_hit) begin
                                mode_next       = stle_pkg::MODE_STREAM;
                                seen_match_next = 1'b1;
                                bar_count_next  = 16'd0;
                            end else begin
                                mode_next = stle_pkg::MODE_SKIP;
                            end
                        end else if (is_eol) begin
                            id_accum_next = 16'd0;
                        end else begin
                            mode_next = stle_pkg::MODE_SKIP;
                        end
                    end
                    stle_pkg::MODE_SKIP: begin
                        if (is_eol) begin
                            mode_next     = stle_pkg::MODE_SEEK_ID;
                            id_accum_next = 16'd0;
                        end
                    end
                    stle_pkg::MODE_STREAM: begin
                        if (is_eol) begin
                            mode_next = stle_pkg::MODE_DONE;
                        end else if (!piece_index_reg[15] && is_bar &&
                                     bar_count_reg != stle_pkg::SAT_16) begin
                            bar_count_next = bar_count_reg + 16'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // outputs
    always_comb begin
        emit = 1'b0;
        if (mode_reg == stle_pkg::MODE_STREAM && !is_eol) begin
            emit = piece_index_reg[15] || (!is_bar && piece_hit);
        end
        out_valid_next   = out_valid_reg && !m_tready;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        out_matched_next = out_matched_reg;
        if (in_accept) begin
            if (is_nul) begin
                out_valid_next   = 1'b1;
                out_byte_next    = 8'd0;
                out_last_next    = 1'b1;
                out_matched_next = seen_match_reg;
            end else if (emit) begin
                out_valid_next   = 1'b1;
                out_byte_next    = c;
                out_last_next    = 1'b0;
                out_matched_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= stle_pkg::MODE_SEEK_ID;
            id_accum_reg   <= 16'd0;
            bar_count_reg  <= 16'd0;
            seen_match_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            id_accum_reg   <= id_accum_next;
            bar_count_reg  <= bar_count_next;
            seen_match_reg <= seen_match_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg    <= out_byte_next;
        out_last_reg    <= out_last_next;
        out_matched_reg <= out_matched_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_matched_reg;

    a_block_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && is_nul) |=> (mode_reg == stle_pkg::MODE_SEEK_ID && !seen_match_reg
                                   && id_accum_reg == 16'd0))
        else $error("state not cleared after block end");

    a_stream_has_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == stle_pkg::MODE_STREAM || mode_reg == stle_pkg::MODE_DONE)
        |-> seen_match_reg)
        else $error("streaming without a matched line");

    a_closing_word_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg) |-> (out_byte_reg == 8'd0))
        else $error("closing word carries a byte");

    a_byte_word_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_last_reg) |-> !out_matched_reg)
        else $error("byte word carries matched flag");

    a_done_is_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !is_nul && mode_reg == stle_pkg::MODE_DONE)
        |=> (!out_valid_reg || $stable(out_byte_reg)) && mode_reg == stle_pkg::MODE_DONE)
        else $error("activity after matched line ended");

endmodule
